FILE: design/dnsq_pkg.sv
// Shared types and constants for the DNS query builder.
package dnsq_pkg;

  localparam int OFF_W  = 9;
  localparam int STEP_W = 5;

  localparam logic [OFF_W-1:0] HDR_SIZE = 9'd12;

  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Sequencer steps of a successful end item
  localparam logic [STEP_W-1:0] STEP_HDR_LAST = 5'd11;
  localparam logic [STEP_W-1:0] STEP_LABEL    = 5'd12;
  localparam logic [STEP_W-1:0] STEP_ZERO     = 5'd13;
  localparam logic [STEP_W-1:0] STEP_TYPE_HI  = 5'd14;
  localparam logic [STEP_W-1:0] STEP_TYPE_LO  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_CLASS_HI = 5'd16;
  localparam logic [STEP_W-1:0] STEP_CLASS_LO = 5'd17;
  localparam logic [STEP_W-1:0] STEP_STATUS   = 5'd18;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_LABEL_LEN = 2'd2,
    ST_NAME_LEN  = 2'd3
  } status_t;

  typedef enum logic {
    FUNC_CHAR = 1'b0,
    FUNC_END  = 1'b1
  } func_t;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_END_OK  = 2'd1,
    CMD_END_ERR = 2'd2
  } cmd_kind_t;

  // One classified command from the front to the back
  typedef struct packed {
    cmd_kind_t        kind;
    logic [OFF_W-1:0] off;     // write offset, or name end for an end item
    logic [7:0]       val;
    logic [15:0]      req_id;
    logic [15:0]      qtype;
    logic             close;   // end item closes an open label
    logic [OFF_W-1:0] lstart;
    logic [7:0]       lcount;
    status_t          status;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [OFF_W-1:0] offset;
    logic [7:0]       byte_value;
    status_t          status;
    logic [OFF_W-1:0] packet_length;
    logic             last;
  } out_item_t;

endpackage

FILE: design/dnsq_if.sv
// Valid/ready channel interfaces for the input and result streams.
interface dnsq_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  name_char;
  logic [15:0] req_id;
  logic [15:0] qtype;

  modport source (output valid, func, name_char, req_id, qtype, input ready);
  modport sink (input valid, func, name_char, req_id, qtype, output ready);
endinterface

interface dnsq_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [8:0] offset;
  logic [7:0] byte_value;
  logic [1:0] status;
  logic [8:0] packet_length;
  logic       last;

  modport source (output valid, kind, offset, byte_value, status, packet_length, last,
                  input ready);
  modport sink (input valid, kind, offset, byte_value, status, packet_length, last,
                output ready);
endinterface

FILE: design/dnsq_front.sv
// Front end: accepts name items, tracks label state and issues commands.
module dnsq_front
  import dnsq_pkg::*;
#(
  parameter int LABEL_MAX = 63,
  parameter int MAX_NAME  = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_name_char,
  input  logic [15:0] in_req_id,
  input  logic [15:0] in_qtype,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int LCW = $clog2(LABEL_MAX + 1);

  logic [OFF_W-1:0] wo_r, wo_nxt;
  logic [OFF_W-1:0] ls_r, ls_nxt;
  logic [LCW-1:0]   lc_r, lc_nxt;
  logic             esc_r, esc_nxt;
  logic             at_start_r, at_start_nxt;
  logic             lone_r, lone_nxt;
  status_t          err_r, err_nxt;

  logic             accept;
  logic [OFF_W-1:0] pos;
  status_t          err_chk;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pos      = at_start_r ? wo_r + OFF_W'(1) : wo_r;

  always_comb begin
    wo_nxt       = wo_r;
    ls_nxt       = ls_r;
    lc_nxt       = lc_r;
    esc_nxt      = esc_r;
    at_start_nxt = at_start_r;
    lone_nxt     = lone_r;
    err_nxt      = err_r;
    err_chk      = err_r;
    q_push       = 1'b0;
    q_cmd        = '0;
    q_cmd.req_id = in_req_id;
    q_cmd.qtype  = in_qtype;
    q_cmd.close  = !at_start_r;
    q_cmd.lstart = ls_r;
    q_cmd.lcount = 8'(lc_r);
    q_cmd.status = err_r;

    if (accept) begin
      if (in_func == FUNC_END) begin
        q_push       = 1'b1;
        q_cmd.kind   = (err_r == ST_OK) ? CMD_END_OK : CMD_END_ERR;
        q_cmd.off    = wo_r;
        // back to the start of a fresh query
        wo_nxt       = HDR_SIZE;
        ls_nxt       = HDR_SIZE;
        lc_nxt       = '0;
        esc_nxt      = 1'b0;
        at_start_nxt = 1'b1;
        lone_nxt     = 1'b0;
        err_nxt      = ST_OK;
      end else if (err_r == ST_EMPTY || err_r == ST_LABEL_LEN) begin
        // drop characters after a hard error
      end else if (lone_r) begin
        err_nxt = ST_EMPTY;
      end else if (esc_r) begin
        // literal character overwrites the backslash
        esc_nxt = 1'b0;
        if (err_r == ST_OK) begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_WRITE;
          q_cmd.off  = wo_r - OFF_W'(1);
          q_cmd.val  = in_name_char;
        end
      end else if (in_name_char == CHAR_DOT) begin
        if (at_start_r) begin
          if (wo_r == HDR_SIZE && err_r == ST_OK) lone_nxt = 1'b1;
          else err_nxt = ST_EMPTY;
        end else begin
          if (err_r == ST_OK) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_WRITE;
            q_cmd.off  = ls_r;
            q_cmd.val  = 8'(lc_r);
          end
          at_start_nxt = 1'b1;
          lc_nxt       = '0;
        end
      end else if (lc_r >= LCW'(LABEL_MAX)) begin
        err_nxt = ST_LABEL_LEN;
      end else begin
        if (err_r == ST_OK && pos > OFF_W'(MAX_NAME + 10)) err_chk = ST_NAME_LEN;
        err_nxt = err_chk;
        if (err_chk == ST_OK) begin
          if (at_start_r) ls_nxt = wo_r;
          q_push     = 1'b1;
          q_cmd.kind = CMD_WRITE;
          q_cmd.off  = pos;
          q_cmd.val  = in_name_char;
          wo_nxt     = pos + OFF_W'(1);
        end
        at_start_nxt = 1'b0;
        lc_nxt       = lc_r + LCW'(1);
        if (in_name_char == CHAR_BSLASH) esc_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wo_r       <= HDR_SIZE;
      ls_r       <= HDR_SIZE;
      lc_r       <= '0;
      esc_r      <= 1'b0;
      at_start_r <= 1'b1;
      lone_r     <= 1'b0;
      err_r      <= ST_OK;
    end else begin
      wo_r       <= wo_nxt;
      ls_r       <= ls_nxt;
      lc_r       <= lc_nxt;
      esc_r      <= esc_nxt;
      at_start_r <= at_start_nxt;
      lone_r     <= lone_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

FILE: design/dnsq_queue.sv
// Short command queue between the front and back ends.
module dnsq_queue
  import dnsq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop) rd_r <= rd_r + QPTR_W'(1);
      if (push && !pop) cnt_r <= cnt_r + QCNT_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

FILE: design/dnsq_back.sv
// Back end: expands commands into result items behind an output register.
module dnsq_back
  import dnsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              ov_r;
  out_item_t         item_r, item_nxt;
  logic              load, final_step;

  assign load      = !q_empty && (!ov_r || out_ready);
  assign q_pop     = load && final_step;
  assign out_valid = ov_r;
  assign out_item  = item_r;

  always_comb begin
    item_nxt   = '0;
    final_step = 1'b1;
    step_nxt   = step_r + STEP_W'(1);
    case (head.kind)
      CMD_WRITE: begin
        item_nxt.kind       = KIND_WRITE;
        item_nxt.offset     = head.off;
        item_nxt.byte_value = head.val;
      end
      CMD_END_OK: begin
        final_step    = (step_r == STEP_STATUS);
        item_nxt.kind = KIND_WRITE;
        if (step_r == STEP_HDR_LAST && !head.close) step_nxt = STEP_ZERO;
        case (step_r)
          5'd0: item_nxt.byte_value = head.req_id[15:8];
          5'd1: item_nxt.byte_value = head.req_id[7:0];
          5'd2: item_nxt.byte_value = 8'h01;  // opcode query, recursion desired
          5'd5: item_nxt.byte_value = 8'h01;  // one question
          default: item_nxt.byte_value = 8'h00;
        endcase
        item_nxt.offset = OFF_W'(step_r);
        case (step_r)
          STEP_LABEL: begin
            item_nxt.offset     = head.lstart;
            item_nxt.byte_value = head.lcount;
          end
          STEP_ZERO: item_nxt.offset = head.off;
          STEP_TYPE_HI: begin
            item_nxt.offset     = head.off + OFF_W'(1);
            item_nxt.byte_value = head.qtype[15:8];
          end
          STEP_TYPE_LO: begin
            item_nxt.offset     = head.off + OFF_W'(2);
            item_nxt.byte_value = head.qtype[7:0];
          end
          STEP_CLASS_HI: item_nxt.offset = head.off + OFF_W'(3);
          STEP_CLASS_LO: begin
            item_nxt.offset     = head.off + OFF_W'(4);
            item_nxt.byte_value = 8'h01;
          end
          STEP_STATUS: begin
            item_nxt.kind          = KIND_STATUS;
            item_nxt.offset        = '0;
            item_nxt.status        = ST_OK;
            item_nxt.packet_length = head.off + OFF_W'(5);
            item_nxt.last          = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_END_ERR: begin
        item_nxt.kind   = KIND_STATUS;
        item_nxt.status = head.status;
        item_nxt.last   = 1'b1;
      end
      default: ;
    endcase
    if (final_step) step_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (load) item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      step_r <= '0;
    end else begin
      if (load) begin
        ov_r   <= 1'b1;
        step_r <= step_nxt;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

FILE: design/dns_query_builder_unit.sv
// DNS query builder: streams a dotted name into packet byte writes and a status.
// A character's write goes through the command queue, then the output register.
// Throughput: one item per cycle unless the queue is full; a character gives at most one
// write; an end item steps through the back-end sequencer (one result per cycle if ready).
// A four-entry command queue lets the front keep accepting while the back drains.
// Reset (synchronous, rst_n low) clears the queue, output register and name state.
module dns_query_builder_unit
  import dnsq_pkg::*;
#(
  parameter int LABEL_MAX = 63,
  parameter int MAX_NAME  = 255
) (
  input logic        clk,
  input logic        rst_n,
  dnsq_in_if.sink    in_ch,
  dnsq_out_if.source out_ch
);

  // Front to queue
  logic q_push, q_full, q_empty, q_pop;
  cmd_t q_cmd, q_head;
  out_item_t item;

  // Classify each item and update label tracking
  dnsq_front #(
    .LABEL_MAX(LABEL_MAX),
    .MAX_NAME (MAX_NAME)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_func     (in_ch.func),
    .in_name_char(in_ch.name_char),
    .in_req_id   (in_ch.req_id),
    .in_qtype    (in_ch.qtype),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  // Hold commands so each side can stall on its own
  dnsq_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Expand commands into byte writes and the completion status
  dnsq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_item (item)
  );

  assign out_ch.kind          = item.kind;
  assign out_ch.offset        = item.offset;
  assign out_ch.byte_value    = item.byte_value;
  assign out_ch.status        = item.status;
  assign out_ch.packet_length = item.packet_length;
  assign out_ch.last          = item.last;

endmodule

FILE: dv/dnsq_query_check_pkg.sv
// Packet write predictor and result scoreboard for the DNS query builder bench.
`timescale 1ns / 100ps
package dnsq_query_check_pkg;
  import dnsq_pkg::*;

  localparam int LABEL_LIMIT = 63;
  localparam int NAME_LIMIT  = 255;
  // last name octet may sit at most at this offset
  localparam int NAME_OFFSET_LIMIT = NAME_LIMIT + 10;

  localparam logic [7:0]  FLAGS_RD   = 8'h01;
  localparam logic [7:0]  QDCOUNT_LO = 8'h01;
  localparam logic [15:0] CLASS_IN   = 16'h0001;

  class query_packet_predictor;
    logic [OFF_W-1:0] wr_off;
    logic [OFF_W-1:0] lab_start;
    logic [6:0]       lab_len;
    bit               esc_due;
    bit               at_start;
    bit               root_seen;
    status_t          err;
    out_item_t        awaited_writes[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      wr_off    = HDR_SIZE;
      lab_start = HDR_SIZE;
      lab_len   = '0;
      esc_due   = 1'b0;
      at_start  = 1'b1;
      root_seen = 1'b0;
      err       = ST_OK;
    endfunction

    function void push_write(logic [OFF_W-1:0] off, logic [7:0] val);
      out_item_t w;
      w.kind          = KIND_WRITE;
      w.offset        = off;
      w.byte_value    = val;
      w.status        = ST_OK;
      w.packet_length = '0;
      w.last          = 1'b0;
      awaited_writes.insert(awaited_writes.size(), w);
    endfunction

    function void push_status(status_t st, logic [OFF_W-1:0] plen);
      out_item_t s;
      s.kind          = KIND_STATUS;
      s.offset        = '0;
      s.byte_value    = '0;
      s.status        = st;
      s.packet_length = plen;
      s.last          = 1'b1;
      awaited_writes.insert(awaited_writes.size(), s);
    endfunction

    function void take_char(logic [7:0] c);
      logic [OFF_W-1:0] pos;
      if (err == ST_EMPTY || err == ST_LABEL_LEN) return;
      // anything after a lone root dot is an empty label
      if (root_seen) begin
        err = ST_EMPTY;
        return;
      end
      // escaped character overwrites the backslash, counts nothing
      if (esc_due) begin
        esc_due = 1'b0;
        if (err == ST_OK) push_write(wr_off - 1'b1, c);
        return;
      end
      if (c == CHAR_DOT) begin
        if (at_start) begin
          if (wr_off == HDR_SIZE && err == ST_OK) root_seen = 1'b1;
          else err = ST_EMPTY;
          return;
        end
        if (err == ST_OK) push_write(lab_start, 8'(lab_len));
        at_start = 1'b1;
        lab_len  = '0;
        return;
      end
      if (lab_len >= LABEL_LIMIT) begin
        err = ST_LABEL_LEN;
        return;
      end
      pos = at_start ? wr_off + 1'b1 : wr_off;
      if (err == ST_OK && pos > NAME_OFFSET_LIMIT) err = ST_NAME_LEN;
      if (err == ST_OK) begin
        if (at_start) begin
          lab_start = wr_off;
          wr_off++;
        end
        push_write(wr_off, c);
        wr_off++;
      end
      at_start = 1'b0;
      lab_len++;
      if (c == CHAR_BSLASH) esc_due = 1'b1;
    endfunction

    function void take_end(logic [15:0] id, logic [15:0] rtype);
      if (err == ST_OK) begin
        push_write(9'd0, id[15:8]);
        push_write(9'd1, id[7:0]);
        push_write(9'd2, FLAGS_RD);
        push_write(9'd3, 8'h00);
        push_write(9'd4, 8'h00);
        push_write(9'd5, QDCOUNT_LO);
        for (int i = 6; i < HDR_SIZE; i++) push_write(OFF_W'(i), 8'h00);
        if (!at_start) push_write(lab_start, 8'(lab_len));
        push_write(wr_off, 8'h00);
        push_write(wr_off + 9'd1, rtype[15:8]);
        push_write(wr_off + 9'd2, rtype[7:0]);
        push_write(wr_off + 9'd3, CLASS_IN[15:8]);
        push_write(wr_off + 9'd4, CLASS_IN[7:0]);
        push_status(ST_OK, wr_off + 9'd5);
      end else begin
        push_status(err, '0);
      end
      restart();
    endfunction

    function void note_item(func_t f, logic [7:0] c, logic [15:0] id, logic [15:0] rtype);
      if (f == FUNC_CHAR) take_char(c);
      else take_end(id, rtype);
    endfunction

    function void check_field(string field, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited_writes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d offset %0d value %0d",
                 $time, got.kind, got.offset, got.byte_value);
        mismatches++;
        return;
      end
      want = awaited_writes.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("offset", want.offset, got.offset);
      check_field("byte_value", want.byte_value, got.byte_value);
      check_field("status", want.status, got.status);
      check_field("packet_length", want.packet_length, got.packet_length);
      check_field("last", want.last, got.last);
    endfunction

    function int pending();
      return awaited_writes.size();
    endfunction
  endclass

endpackage

FILE: dv/tb_dns_query_builder_unit.sv
// Top-level bench for the DNS query builder: directed and random names, checked per write.
`timescale 1ns / 100ps
module tb_dns_query_builder_unit;
  import dnsq_pkg::*;
  import dnsq_query_check_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_TARGET  = 330;   // directed, one long label, one long name, short names
  localparam int HOLD_AFTER   = 120;   // results taken before the long receiver hold-off
  localparam int HOLD_CYCLES  = 200;
  localparam int CALM_FROM    = 360;   // window with no idling on either side
  localparam int CALM_TO      = 560;
  localparam int DRAIN_CYCLES = 30;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   items_sent  = 0;

  dnsq_in_if  in_if();
  dnsq_out_if out_if();

  query_packet_predictor pkt_pred = new();

  dns_query_builder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count cycles and give up at a generous limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** dns_query_builder_unit: FAILED **");
      $finish;
    end
  end

  function automatic bit gaps_on();
    return !(cycle_count >= CALM_FROM && cycle_count < CALM_TO);
  endfunction

  // Note every accepted input item before checking results at the same edge;
  // an item can never produce a result at the edge it is accepted on.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        pkt_pred.note_item(func_t'(in_if.func), in_if.name_char, in_if.req_id,
                           in_if.qtype);
      if (out_if.valid && out_if.ready)
        pkt_pred.check_result({out_if.kind, out_if.offset, out_if.byte_value,
                               out_if.status, out_if.packet_length, out_if.last});
    end
  end

  // Receiver: random stalls, a calm window, and one long hold-off that lets the
  // command queue fill so the input side has to stall.
  initial begin
    int  taken;
    int  hold_left;
    bit  held_once;
    taken = 0;
    hold_left = 0;
    held_once = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) taken++;
      if (!held_once && taken >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (gaps_on() && $urandom_range(0, 99) < 10) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one item and hold it until accepted; leave valid high so a following
  // item can go out back to back. Idle gaps drop valid first.
  task automatic send_item(input func_t f, input logic [7:0] c, input logic [15:0] id,
                           input logic [15:0] rtype);
    while (gaps_on() && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= f;
    in_if.name_char <= c;
    in_if.req_id    <= id;
    in_if.qtype     <= rtype;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Unused fields carry random values so every input bit toggles
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_item(FUNC_CHAR, s[i], 16'($urandom), 16'($urandom));
  endtask

  task automatic send_end(input logic [15:0] id, input logic [15:0] rtype);
    send_item(FUNC_END, 8'($urandom), id, rtype);
  endtask

  // Mostly host-name characters; with noise allowed, also escapes and any byte
  function automatic logic [7:0] pick_name_char(input bit plain);
    string alnum;
    int    r;
    alnum = "abcdefghijklmnopqrstuvwxyz0123456789-";
    r = $urandom_range(0, 99);
    if (plain || r < 80) return alnum[$urandom_range(0, alnum.len() - 1)];
    if (r < 88) return CHAR_BSLASH;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_label(input int len, input bit plain);
    for (int i = 0; i < len; i++)
      send_item(FUNC_CHAR, pick_name_char(plain), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int  q;
    int  r;
    int  nl;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.func      <= FUNC_CHAR;
    in_if.name_char <= '0;
    in_if.req_id    <= '0;
    in_if.qtype     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: root name, extreme ids and types, empty labels, escapes,
    // trailing dot, zero and top octets, trailing backslash
    send_text(".");
    send_end(16'h0000, 16'h0000);
    send_text("a");
    send_end(16'hFFFF, 16'hFFFF);
    send_text(".x");
    send_end(16'h1234, 16'h0001);
    send_text("a..");
    send_end(16'h8001, 16'h001C);
    send_text("\\.b.");
    send_end(16'h0F0F, 16'h00FF);
    send_item(FUNC_CHAR, 8'h00, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_CHAR, 8'hFF, 16'h0000, 16'h0000);
    send_text("\\");
    send_end(16'hA5C3, 16'h5A3C);

    // Random: one long label near the limit, one long name near the limit,
    // and otherwise short names, root names and noise
    q = 0;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (q == 1) begin
        // label length straddles the label limit
        send_label($urandom_range(LABEL_LIMIT - 1, LABEL_LIMIT + 2), 1'b1);
      end else if (q == 3) begin
        // three full labels, then a fourth that ends just below or past the name limit
        for (int i = 0; i < 3; i++) begin
          send_label(LABEL_LIMIT, 1'b1);
          send_text(".");
        end
        send_label($urandom_range(LABEL_LIMIT - 3, LABEL_LIMIT), 1'b1);
        // an empty label after a long name replaces its status
        if ($urandom_range(0, 1)) send_text("x..");
      end else if (r < 6) begin
        send_text(".");
        if ($urandom_range(0, 2) == 0) send_label(1, 1'b0);
      end else if (r < 20) begin
        // noise: dots, escapes and any byte in any order
        for (int i = $urandom_range(1, 10); i > 0; i--) begin
          case ($urandom_range(0, 9))
            0, 1, 2: send_text(".");
            3:       send_text("\\");
            default: send_item(FUNC_CHAR, 8'($urandom), 16'($urandom), 16'($urandom));
          endcase
        end
      end else begin
        nl = $urandom_range(1, 4);
        for (int l = 0; l < nl; l++) begin
          send_label($urandom_range(1, 12), 1'b0);
          if (l < nl - 1 || $urandom_range(0, 3) == 0) send_text(".");
        end
      end
      send_end(16'($urandom), 16'($urandom));
      q++;
    end
    in_if.valid <= 1'b0;

    // Drain, then allow the pipeline to settle before the verdict
    while (pkt_pred.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pkt_pred.mismatches == 0 && pkt_pred.pending() == 0) begin
      $display("** dns_query_builder_unit: PASSED **");
    end else begin
      $display("** dns_query_builder_unit: FAILED **");
    end
    $finish;
  end

endmodule
